// File: hw/rtl/hsr_pkg.sv
package hsr_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 17;
    localparam int STEP_W   = 20;
    localparam int ACT_W    = 2;

    // phase fraction bits, Q(FRAC_BITS)
    localparam int FRAC_BITS = 16;

    // phase holds below one plus the largest step
    localparam int PHASE_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;

    // horner accumulator, magnitude stays below 24 * 2^(FRAC_BITS+15)
    localparam int SUM_W  = FRAC_BITS + 21;
    localparam int PROD_W = SUM_W + FRAC_BITS + 1;

    // coefficient widths
    localparam int D1_W = 17;
    localparam int D2_W = 20;
    localparam int D3_W = 19;

    // results per item
    localparam int MAX_OUT = 64;
    localparam int CNT_W   = $clog2(MAX_OUT);

    // history fill
    localparam int PRIME_W = 3;
    localparam logic [PRIME_W-1:0] PRIME_FULL = PRIME_W'(4);

    // command queue, depth a power of two
    localparam int CMD_DEPTH = 4;
    localparam int QPTR_W    = $clog2(CMD_DEPTH);
    localparam int QCNT_W    = $clog2(CMD_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [3:0]              t_taps;
    typedef logic [PHASE_W-1:0]         t_phase;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic [CNT_W-1:0]           t_cnt;

    localparam logic [STEP_W-1:0] RATIO_RESET = STEP_W'(65536);
    localparam t_phase PHASE_ONE = t_phase'(1) << FRAC_BITS;
    localparam t_sum TRUNC_BIAS = (t_sum'(1) <<< (FRAC_BITS + 1)) - t_sum'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_FRAME   = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_PRIME,
        CMD_STEP,
        CMD_END
    } t_cmd_kind;

    // one command: taps[0] left, taps[1] right, tap 0 oldest
    typedef struct packed {
        t_cmd_kind   kind;
        t_taps [1:0] taps;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S2,
        ST_S1,
        ST_S0,
        ST_PUT
    } t_back_state;

endpackage

// File: hw/rtl/hsr_if.sv
// source frame channel
interface hsr_in_if;
    logic                              valid;
    logic                              ready;
    logic [hsr_pkg::ACT_W-1:0]         action;
    logic signed [hsr_pkg::SAMPLE_W-1:0] left_in;
    logic signed [hsr_pkg::SAMPLE_W-1:0] right_in;

    modport source (output valid, action, left_in, right_in, input ready);
    modport sink   (input valid, action, left_in, right_in, output ready);
endinterface

// result channel
interface hsr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [hsr_pkg::OUT_W-1:0] left_out;
    logic signed [hsr_pkg::OUT_W-1:0] right_out;
    logic                             last;
    logic                             stream_end;

    modport source (output valid, left_out, right_out, last, stream_end, input ready);
    modport sink   (input valid, left_out, right_out, last, stream_end, output ready);
endinterface

// ratio step write channel
interface hsr_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hsr_pkg::STEP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/hsr_front.sv
module hsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsr_in_if.sink        i_src,
    input  logic          i_q_full,
    output logic          o_push,
    output hsr_pkg::t_cmd o_cmd
);

    hsr_pkg::t_taps [1:0]            r_hist;
    hsr_pkg::t_taps [1:0]            n_hist;
    logic [hsr_pkg::PRIME_W-1:0]     r_prime;
    logic [hsr_pkg::PRIME_W-1:0]     n_prime;
    logic                            r_finished;
    logic                            n_finished;
    logic                            w_accept;
    hsr_pkg::t_sample [1:0]          w_smp;
    hsr_pkg::t_taps [1:0]            w_shift;
    logic                            w_mid_zero;

    // take items whenever the queue has room
    assign i_src.ready = !i_q_full;
    assign w_accept    = i_src.valid && !i_q_full;

    // end of stream shifts in silence
    always_comb begin
        if (i_src.action == hsr_pkg::ACT_FRAME) begin
            w_smp[0] = i_src.left_in;
            w_smp[1] = i_src.right_in;
        end else begin
            w_smp[0] = '0;
            w_smp[1] = '0;
        end
        for (int c = 0; c < 2; c++) begin
            w_shift[c] = {w_smp[c], r_hist[c][3:1]};
        end
        w_mid_zero = (w_shift[0][1] == '0) && (w_shift[0][2] == '0) &&
                     (w_shift[1][1] == '0) && (w_shift[1][2] == '0);
    end

    // classify the item and update history
    always_comb begin
        n_hist      = r_hist;
        n_prime     = r_prime;
        n_finished  = r_finished;
        o_push      = 1'b0;
        o_cmd.kind  = hsr_pkg::CMD_CLEAR;
        o_cmd.taps  = w_shift;
        if (w_accept) begin
            case (i_src.action)
                hsr_pkg::ACT_RESTART: begin
                    n_hist     = '0;
                    n_prime    = '0;
                    n_finished = 1'b0;
                    o_push     = 1'b1;
                    o_cmd.kind = hsr_pkg::CMD_CLEAR;
                end
                hsr_pkg::ACT_FRAME, hsr_pkg::ACT_END: begin
                    if (!r_finished) begin
                        if (r_prime != hsr_pkg::PRIME_FULL) begin
                            if (i_src.action == hsr_pkg::ACT_END) begin
                                n_finished = 1'b1;
                                o_push     = 1'b1;
                                o_cmd.kind = hsr_pkg::CMD_END;
                            end else begin
                                n_hist  = w_shift;
                                n_prime = r_prime + 1'b1;
                                if (r_prime == hsr_pkg::PRIME_FULL - 1'b1) begin
                                    o_push     = 1'b1;
                                    o_cmd.kind = hsr_pkg::CMD_PRIME;
                                end
                            end
                        end else begin
                            n_hist = w_shift;
                            o_push = 1'b1;
                            if (i_src.action == hsr_pkg::ACT_END && w_mid_zero) begin
                                n_finished = 1'b1;
                                o_cmd.kind = hsr_pkg::CMD_END;
                            end else begin
                                o_cmd.kind = hsr_pkg::CMD_STEP;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_prime    <= '0;
            r_finished <= 1'b0;
        end else begin
            r_hist     <= n_hist;
            r_prime    <= n_prime;
            r_finished <= n_finished;
        end
    end

endmodule

// File: hw/rtl/hsr_cmd_fifo.sv
module hsr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output hsr_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    hsr_pkg::t_cmd              r_entry [hsr_pkg::CMD_DEPTH];
    logic [hsr_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [hsr_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [hsr_pkg::QCNT_W-1:0] r_count;

    assign o_full  = (r_count == hsr_pkg::QCNT_W'(hsr_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/hsr_back.sv
module hsr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  hsr_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    input  logic [hsr_pkg::STEP_W-1:0] i_step,
    hsr_out_if.source                  o_res
);

    hsr_pkg::t_back_state r_state;
    hsr_pkg::t_back_state n_state;
    hsr_pkg::t_phase      r_phase;
    hsr_pkg::t_phase      n_phase;
    hsr_pkg::t_cnt        r_count;
    hsr_pkg::t_cnt        n_count;
    logic                 r_is_end;

    // per channel coefficients and horner accumulator
    logic signed [hsr_pkg::D1_W-1:0]     r_d1  [2];
    logic signed [hsr_pkg::D2_W-1:0]     r_d2  [2];
    logic signed [hsr_pkg::D3_W-1:0]     r_d3  [2];
    hsr_pkg::t_sample                    r_h1  [2];
    hsr_pkg::t_sum                       r_acc [2];
    hsr_pkg::t_sum                       n_acc [2];
    logic signed [hsr_pkg::D1_W-1:0]     w_d1  [2];
    logic signed [hsr_pkg::D2_W-1:0]     w_d2  [2];
    logic signed [hsr_pkg::D3_W-1:0]     w_d3  [2];
    logic signed [hsr_pkg::D2_W-1:0]     w_e   [2][4];
    logic signed [hsr_pkg::D2_W-1:0]     w_d3w [2];

    // shared multiplier per channel
    hsr_pkg::t_sum                       w_mop  [2];
    hsr_pkg::t_prod                      w_prod [2];
    logic signed [hsr_pkg::FRAC_BITS:0]  w_pf;

    hsr_pkg::t_sum                       w_trunc [2];
    hsr_pkg::t_phase                     w_step_phase;
    hsr_pkg::t_phase                     w_next_phase;
    logic                                w_slot;
    logic                                w_last;
    logic                                w_load;
    logic                                w_load_end;

    // output register
    logic                                r_out_valid;
    logic signed [hsr_pkg::OUT_W-1:0]    r_left;
    logic signed [hsr_pkg::OUT_W-1:0]    r_right;
    logic                                r_last;
    logic                                r_end;

    assign o_res.valid      = r_out_valid;
    assign o_res.left_out   = r_left;
    assign o_res.right_out  = r_right;
    assign o_res.last       = r_last;
    assign o_res.stream_end = r_end;

    assign w_slot = !r_out_valid || o_res.ready;
    assign w_pf   = {1'b0, r_phase[hsr_pkg::FRAC_BITS-1:0]};

    // phase after a new source frame, clamped at zero
    assign w_step_phase = (r_phase >= hsr_pkg::PHASE_ONE) ?
                          (r_phase - hsr_pkg::PHASE_ONE) : '0;
    assign w_next_phase = r_phase + hsr_pkg::t_phase'(i_step);
    assign w_last       = (w_next_phase >= hsr_pkg::PHASE_ONE) ||
                          (r_count == hsr_pkg::t_cnt'(hsr_pkg::MAX_OUT - 1));

    // coefficients from the four taps
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 4; k++) begin
                w_e[c][k] = hsr_pkg::D2_W'($signed(i_cmd.taps[c][k]));
            end
            w_d1[c]  = hsr_pkg::D1_W'(w_e[c][2] - w_e[c][0]);
            w_d2[c]  = (w_e[c][2] <<< 2) + (w_e[c][0] <<< 1)
                       - (w_e[c][1] <<< 2) - w_e[c][1] - w_e[c][3];
            w_d3w[c] = (w_e[c][1] <<< 1) + w_e[c][1] - (w_e[c][2] <<< 1)
                       - w_e[c][2] - w_e[c][0] + w_e[c][3];
            w_d3[c]  = w_d3w[c][hsr_pkg::D3_W-1:0];
        end
    end

    // multiplier operand select and product
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_state == hsr_pkg::ST_S2) begin
                w_mop[c] = hsr_pkg::t_sum'(r_d3[c]);
            end else begin
                w_mop[c] = r_acc[c];
            end
            w_prod[c]  = hsr_pkg::t_prod'(w_mop[c]) * hsr_pkg::t_prod'(w_pf);
            w_trunc[c] = r_acc[c] + (r_acc[c][hsr_pkg::SUM_W-1] ? hsr_pkg::TRUNC_BIAS : '0);
        end
    end

    // sequencer: one horner step per cycle, then hand the result over
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_count    = r_count;
        o_pop      = 1'b0;
        w_load     = 1'b0;
        w_load_end = 1'b0;
        for (int c = 0; c < 2; c++) begin
            n_acc[c] = r_acc[c];
        end
        case (r_state)
            hsr_pkg::ST_IDLE: begin
                o_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        hsr_pkg::CMD_CLEAR: begin
                            n_phase = '0;
                        end
                        hsr_pkg::CMD_PRIME: begin
                            n_phase = '0;
                            n_count = '0;
                            n_state = hsr_pkg::ST_S2;
                        end
                        hsr_pkg::CMD_STEP: begin
                            n_phase = w_step_phase;
                            n_count = '0;
                            if (w_step_phase < hsr_pkg::PHASE_ONE) begin
                                n_state = hsr_pkg::ST_S2;
                            end
                        end
                        hsr_pkg::CMD_END: begin
                            n_state = hsr_pkg::ST_PUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hsr_pkg::ST_S2: begin
                for (int c = 0; c < 2; c++) begin
                    n_acc[c] = (hsr_pkg::t_sum'(r_d2[c]) <<< hsr_pkg::FRAC_BITS)
                               + w_prod[c][hsr_pkg::SUM_W-1:0];
                end
                n_state = hsr_pkg::ST_S1;
            end
            hsr_pkg::ST_S1: begin
                for (int c = 0; c < 2; c++) begin
                    n_acc[c] = (hsr_pkg::t_sum'(r_d1[c]) <<< hsr_pkg::FRAC_BITS)
                               + $signed(w_prod[c][hsr_pkg::SUM_W+hsr_pkg::FRAC_BITS-1:
                                                   hsr_pkg::FRAC_BITS]);
                end
                n_state = hsr_pkg::ST_S0;
            end
            hsr_pkg::ST_S0: begin
                for (int c = 0; c < 2; c++) begin
                    n_acc[c] = (hsr_pkg::t_sum'(r_h1[c]) <<< (hsr_pkg::FRAC_BITS + 1))
                               + $signed(w_prod[c][hsr_pkg::SUM_W+hsr_pkg::FRAC_BITS-1:
                                                   hsr_pkg::FRAC_BITS]);
                end
                n_state = hsr_pkg::ST_PUT;
            end
            hsr_pkg::ST_PUT: begin
                if (w_slot) begin
                    if (r_is_end) begin
                        w_load_end = 1'b1;
                        n_state    = hsr_pkg::ST_IDLE;
                    end else begin
                        w_load  = 1'b1;
                        n_phase = w_next_phase;
                        n_count = r_count + 1'b1;
                        n_state = w_last ? hsr_pkg::ST_IDLE : hsr_pkg::ST_S2;
                    end
                end
            end
            default: begin
                n_state = hsr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsr_pkg::ST_IDLE;
            r_phase     <= '0;
            r_count     <= '0;
            r_is_end    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            if (o_pop) begin
                r_is_end <= (i_cmd.kind == hsr_pkg::CMD_END);
            end
            if (w_load || w_load_end) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            r_acc[c] <= n_acc[c];
            if (o_pop) begin
                r_d1[c] <= w_d1[c];
                r_d2[c] <= w_d2[c];
                r_d3[c] <= w_d3[c];
                r_h1[c] <= $signed(i_cmd.taps[c][1]);
            end
        end
        if (w_load) begin
            r_left  <= w_trunc[0][hsr_pkg::FRAC_BITS+hsr_pkg::OUT_W:hsr_pkg::FRAC_BITS+1];
            r_right <= w_trunc[1][hsr_pkg::FRAC_BITS+hsr_pkg::OUT_W:hsr_pkg::FRAC_BITS+1];
            r_last  <= w_last;
            r_end   <= 1'b0;
        end else if (w_load_end) begin
            r_left  <= '0;
            r_right <= '0;
            r_last  <= 1'b1;
            r_end   <= 1'b1;
        end
    end

endmodule

// File: hw/rtl/hermite_stereo_resampler.sv
// path: an accepted item passes the command queue, then the back end pops it in IDLE and
//   walks S2, S1, S0 and PUT for each result, as one shared multiplier per channel walks
//   the three horner steps; PUT loads the output register, an end marker skips to PUT
// input side runs ahead through a 4-entry command queue, ready drops only when it is full
// reset: synchronous active low, clears history, fill count, phase, finished flag, queue
//   and output valid; ratio step returns to 1.0, no clearing pass
module hermite_stereo_resampler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsr_in_if.sink    i_src,
    hsr_cfg_if.sink   i_cfg,
    hsr_out_if.source o_res
);

    logic [hsr_pkg::STEP_W-1:0] r_ratio_step;
    logic                       w_push;
    hsr_pkg::t_cmd              w_push_cmd;
    logic                       w_q_full;
    logic                       w_q_valid;
    hsr_pkg::t_cmd              w_q_cmd;
    logic                       w_pop;

    // ratio step register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_step <= hsr_pkg::RATIO_RESET;
        end else if (i_cfg.valid) begin
            r_ratio_step <= i_cfg.data;
        end
    end

    // front end: history and item classification
    hsr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // command queue
    hsr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // back end: phase loop and interpolation
    hsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .i_step      (r_ratio_step),
        .o_res       (o_res)
    );

    // end marker carries silence and closes its item
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.stream_end) |->
            (o_res.last && o_res.left_out == '0 && o_res.right_out == '0))
        else $error("end marker with nonzero samples or without last");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("command pushed into full queue");

    // the back only pops a queued command
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command popped from empty queue");

endmodule
